@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared types, sizes and codes for the first-fit heap block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 40;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [15:0] alloc_size;
    logic [15:0] block_address;
  } alloc_req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } alloc_rsp_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        is_free;
  } blk_entry_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_CHECK,
    FSM_SHIFT_RD,
    FSM_SHIFT_WR,
    FSM_SPLIT_HI,
    FSM_SPLIT_LO,
    FSM_APPEND,
    FSM_DONE
  } fsm_state_t;

endpackage

@@ rtl/first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator unit
// Address-ordered block table with first-fit allocate, split and free.
// ----------------------------------------------------------------------------
// Each request walks the table entries in order, and an allocation that
// splits an entry first moves the entries above it up by one to make room
// for the new entry; the table holds up to 64 entries. The walk and the
// shift both go through the block table, which has one write port and one
// registered read port. The result is held in an output register, so the
// next request can be taken while a finished result still waits.
module first_fit_block_allocator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::alloc_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::alloc_rsp_t out_data
);

  localparam int IW = ffba_pkg::IDX_W;
  localparam int CW = ffba_pkg::CNT_W;

  ffba_pkg::blk_entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::blk_entry_t rdata_r;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  ffba_pkg::blk_entry_t mem_wdata;
  logic [IW-1:0]        mem_raddr;

  ffba_pkg::fsm_state_t state_r, state_nxt;
  ffba_pkg::alloc_req_t req_r, req_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        sh_r, sh_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic [16:0]          top_r, top_nxt;
  logic [15:0]          ent_start_r, ent_start_nxt;
  logic [15:0]          ent_size_r, ent_size_nxt;
  ffba_pkg::alloc_rsp_t res_r, res_nxt;
  ffba_pkg::alloc_rsp_t out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic        walk_end;
  logic [16:0] chk_pay;
  logic        chk_match;
  logic        chk_fit;
  logic        chk_split;
  logic        shift_more;
  logic        shift_first;
  logic [17:0] app_pay;
  logic [17:0] app_top;
  logic        app_full;
  logic        out_free;

  assign walk_end    = (idx_r == total_r);
  assign chk_pay     = {1'b0, rdata_r.start} + 17'(ffba_pkg::HEADER_BYTES);
  assign chk_match   = (chk_pay == {1'b0, req_r.block_address});
  assign chk_fit     = rdata_r.is_free && (req_r.alloc_size <= rdata_r.size);
  assign chk_split   = ({2'b0, rdata_r.size} >=
                        18'(ffba_pkg::HEADER_BYTES) + {2'b0, req_r.alloc_size} + 18'd1)
                       && (total_r < CW'(ffba_pkg::MAX_BLOCKS));
  assign shift_first = (total_r > idx_r + CW'(1));
  assign shift_more  = (sh_r - CW'(1) > idx_r + CW'(1));
  assign app_pay     = {1'b0, top_r} + 18'(ffba_pkg::HEADER_BYTES);
  assign app_top     = app_pay + {2'b0, req_r.alloc_size};
  assign app_full    = (total_r >= CW'(ffba_pkg::MAX_BLOCKS))
                       || (app_top > 18'(ffba_pkg::HEAP_BYTES))
                       || (app_pay > 18'h0FFFF);
  assign out_free    = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ffba_pkg::FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = ffba_pkg::FSM_READ;
        end
      end
      ffba_pkg::FSM_READ: begin
        if (!walk_end) begin
          state_nxt = ffba_pkg::FSM_CHECK;
        end else if (req_r.opcode == ffba_pkg::OP_ALLOC) begin
          state_nxt = ffba_pkg::FSM_APPEND;
        end else begin
          state_nxt = ffba_pkg::FSM_DONE;
        end
      end
      ffba_pkg::FSM_CHECK: begin
        if (req_r.opcode == ffba_pkg::OP_FREE) begin
          state_nxt = chk_match ? ffba_pkg::FSM_DONE : ffba_pkg::FSM_READ;
        end else if (!chk_fit) begin
          state_nxt = ffba_pkg::FSM_READ;
        end else if (!chk_split) begin
          state_nxt = ffba_pkg::FSM_DONE;
        end else if (shift_first) begin
          state_nxt = ffba_pkg::FSM_SHIFT_RD;
        end else begin
          state_nxt = ffba_pkg::FSM_SPLIT_HI;
        end
      end
      ffba_pkg::FSM_SHIFT_RD: begin
        state_nxt = ffba_pkg::FSM_SHIFT_WR;
      end
      ffba_pkg::FSM_SHIFT_WR: begin
        state_nxt = shift_more ? ffba_pkg::FSM_SHIFT_RD : ffba_pkg::FSM_SPLIT_HI;
      end
      ffba_pkg::FSM_SPLIT_HI: begin
        state_nxt = ffba_pkg::FSM_SPLIT_LO;
      end
      ffba_pkg::FSM_SPLIT_LO: begin
        state_nxt = ffba_pkg::FSM_DONE;
      end
      ffba_pkg::FSM_APPEND: begin
        state_nxt = ffba_pkg::FSM_DONE;
      end
      ffba_pkg::FSM_DONE: begin
        if (out_free) begin
          state_nxt = ffba_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[IW-1:0];
    mem_wdata = '{start: rdata_r.start, size: rdata_r.size, is_free: 1'b0};
    mem_raddr = idx_r[IW-1:0];
    case (state_r)
      ffba_pkg::FSM_CHECK: begin
        if (req_r.opcode == ffba_pkg::OP_FREE) begin
          mem_we    = chk_match;
          mem_wdata = '{start: rdata_r.start, size: rdata_r.size, is_free: 1'b1};
        end else begin
          mem_we = chk_fit && !chk_split;
        end
      end
      ffba_pkg::FSM_SHIFT_RD: begin
        mem_raddr = IW'(sh_r - CW'(1));
      end
      ffba_pkg::FSM_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r[IW-1:0];
        mem_wdata = rdata_r;
      end
      ffba_pkg::FSM_SPLIT_HI: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_r + CW'(1));
        mem_wdata = '{start: ent_start_r + 16'(ffba_pkg::HEADER_BYTES) + req_r.alloc_size,
                      size: ent_size_r - req_r.alloc_size - 16'(ffba_pkg::HEADER_BYTES),
                      is_free: 1'b1};
      end
      ffba_pkg::FSM_SPLIT_LO: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: ent_start_r, size: req_r.alloc_size, is_free: 1'b0};
      end
      ffba_pkg::FSM_APPEND: begin
        mem_we    = !app_full;
        mem_waddr = total_r[IW-1:0];
        mem_wdata = '{start: top_r[15:0], size: req_r.alloc_size, is_free: 1'b0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    total_nxt     = total_r;
    top_nxt       = top_r;
    ent_start_nxt = ent_start_r;
    ent_size_nxt  = ent_size_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ffba_pkg::FSM_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
        end
      end
      ffba_pkg::FSM_READ: begin
        if (walk_end && req_r.opcode == ffba_pkg::OP_FREE) begin
          res_nxt = '{payload_address: 16'd0, status: ffba_pkg::ST_NOT_FOUND};
        end
      end
      ffba_pkg::FSM_CHECK: begin
        ent_start_nxt = rdata_r.start;
        ent_size_nxt  = rdata_r.size;
        sh_nxt        = total_r;
        if (req_r.opcode == ffba_pkg::OP_FREE) begin
          if (chk_match) begin
            res_nxt = '{payload_address: 16'd0, status: ffba_pkg::ST_FREED};
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else if (chk_fit) begin
          res_nxt = '{payload_address: chk_pay[15:0], status: ffba_pkg::ST_ALLOCATED};
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ffba_pkg::FSM_SHIFT_WR: begin
        sh_nxt = sh_r - CW'(1);
      end
      ffba_pkg::FSM_SPLIT_LO: begin
        total_nxt = total_r + CW'(1);
      end
      ffba_pkg::FSM_APPEND: begin
        if (app_full) begin
          res_nxt = '{payload_address: 16'd0, status: ffba_pkg::ST_NO_SPACE};
        end else begin
          res_nxt   = '{payload_address: app_pay[15:0], status: ffba_pkg::ST_ALLOCATED};
          total_nxt = total_r + CW'(1);
          top_nxt   = app_top[16:0];
        end
      end
      ffba_pkg::FSM_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::FSM_IDLE;
      total_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    idx_r       <= idx_nxt;
    sh_r        <= sh_nxt;
    ent_start_r <= ent_start_nxt;
    ent_size_r  <= ent_size_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(ffba_pkg::MAX_BLOCKS))
    else $error("block count exceeds table size");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r == $past(total_r)) || (total_r == $past(total_r) + CW'(1)))
    else $error("block count changed by other than one");

  a_top_append: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (top_r != $past(top_r)) |-> $past(state_r == ffba_pkg::FSM_APPEND))
    else $error("heap top moved outside of an append");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ffba_pkg::FSM_DONE))
    else $error("result presented without a completed request");
`endif

endmodule

@@ test/first_fit_block_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator checker
// Watches the request and response channels of the allocator, keeps its own
// copy of the block table and heap top, predicts the response to every
// accepted request and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module first_fit_block_allocator_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  ffba_pkg::alloc_req_t in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  ffba_pkg::alloc_rsp_t out_data,
  output int                   error_count,
  output int                   rsp_outstanding,
  output int                   alloc_count,
  output int                   freed_count,
  output int                   not_found_count,
  output int                   no_space_count,
  output int                   split_count,
  output int                   whole_on_full_count,
  output int                   peak_blocks
);

  logic [15:0] blk_start [ffba_pkg::MAX_BLOCKS];
  logic [15:0] blk_size  [ffba_pkg::MAX_BLOCKS];
  logic        blk_free  [ffba_pkg::MAX_BLOCKS];
  int          blk_count = 0;
  logic [16:0] heap_end = '0;
  ffba_pkg::alloc_rsp_t pending_rsp [$];

  int n_mismatch   = 0;
  int n_alloc      = 0;
  int n_freed      = 0;
  int n_not_found  = 0;
  int n_no_space   = 0;
  int n_split      = 0;
  int n_whole_full = 0;
  int n_peak       = 0;

  function automatic ffba_pkg::alloc_rsp_t first_fit_alloc(input logic [15:0] size);
    ffba_pkg::alloc_rsp_t rsp;
    int payload;
    int new_end;
    rsp.payload_address = '0;
    rsp.status = ffba_pkg::ST_NO_SPACE;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && size <= blk_size[i]) begin
        blk_free[i] = 1'b0;
        if (int'(blk_size[i]) >= ffba_pkg::HEADER_BYTES + int'(size) + 1) begin
          if (blk_count < ffba_pkg::MAX_BLOCKS) begin
            for (int j = blk_count; j > i + 1; j--) begin
              blk_start[j] = blk_start[j - 1];
              blk_size[j]  = blk_size[j - 1];
              blk_free[j]  = blk_free[j - 1];
            end
            blk_start[i + 1] = 16'(int'(blk_start[i]) + ffba_pkg::HEADER_BYTES + int'(size));
            blk_size[i + 1]  = 16'(int'(blk_size[i]) - int'(size) - ffba_pkg::HEADER_BYTES);
            blk_free[i + 1]  = 1'b1;
            blk_size[i]      = size;
            blk_count++;
            n_split++;
          end else begin
            n_whole_full++;
          end
        end
        rsp.payload_address = 16'(int'(blk_start[i]) + ffba_pkg::HEADER_BYTES);
        rsp.status = ffba_pkg::ST_ALLOCATED;
        return rsp;
      end
    end
    payload = int'(heap_end) + ffba_pkg::HEADER_BYTES;
    new_end = payload + int'(size);
    if (blk_count >= ffba_pkg::MAX_BLOCKS || new_end > ffba_pkg::HEAP_BYTES
        || payload > 'hFFFF) begin
      return rsp;
    end
    blk_start[blk_count] = heap_end[15:0];
    blk_size[blk_count]  = size;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    heap_end = 17'(new_end);
    rsp.payload_address = 16'(payload);
    rsp.status = ffba_pkg::ST_ALLOCATED;
    return rsp;
  endfunction

  function automatic ffba_pkg::alloc_rsp_t free_by_address(input logic [15:0] addr);
    ffba_pkg::alloc_rsp_t rsp;
    rsp.payload_address = '0;
    rsp.status = ffba_pkg::ST_NOT_FOUND;
    for (int i = 0; i < blk_count; i++) begin
      if (int'(blk_start[i]) + ffba_pkg::HEADER_BYTES == int'(addr)) begin
        blk_free[i] = 1'b1;
        rsp.status = ffba_pkg::ST_FREED;
        return rsp;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    ffba_pkg::alloc_rsp_t want;
    if (!rst_n) begin
      blk_count = 0;
      heap_end = '0;
      pending_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response: payload_address %0d, status %0d",
                 out_data.payload_address, out_data.status);
          n_mismatch++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_data.payload_address !== want.payload_address) begin
            $error("payload_address mismatch: expected %0d, actual %0d",
                   want.payload_address, out_data.payload_address);
            n_mismatch++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            n_mismatch++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == ffba_pkg::OP_ALLOC) begin
          want = first_fit_alloc(in_data.alloc_size);
        end else begin
          want = free_by_address(in_data.block_address);
        end
        case (want.status)
          ffba_pkg::ST_ALLOCATED: n_alloc++;
          ffba_pkg::ST_FREED:     n_freed++;
          ffba_pkg::ST_NOT_FOUND: n_not_found++;
          default:                n_no_space++;
        endcase
        if (blk_count > n_peak) begin
          n_peak = blk_count;
        end
        pending_rsp.push_back(want);
      end
    end
    error_count         <= n_mismatch;
    rsp_outstanding     <= pending_rsp.size();
    alloc_count         <= n_alloc;
    freed_count         <= n_freed;
    not_found_count     <= n_not_found;
    no_space_count      <= n_no_space;
    split_count         <= n_split;
    whole_on_full_count <= n_whole_full;
    peak_blocks         <= n_peak;
  end

endmodule

@@ test/tb_first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives a directed set of allocate and free requests that walk the heap to
// its limits, then a long random mix of allocations and frees, most of the
// frees aimed at addresses that were handed out. Both channels stall at
// random; the checker module predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_unit;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ffba_pkg::alloc_req_t in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ffba_pkg::alloc_rsp_t out_data;
  logic                 steady_flow = 1'b0;

  int error_count;
  int rsp_outstanding;
  int alloc_count;
  int freed_count;
  int not_found_count;
  int no_space_count;
  int split_count;
  int whole_on_full_count;
  int peak_blocks;

  logic [15:0]          live_addr [$];
  logic [15:0]          freed_addr [$];
  ffba_pkg::alloc_req_t directed_reqs [$];

  first_fit_block_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  first_fit_block_allocator_checker heap_watch (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .error_count         (error_count),
    .rsp_outstanding     (rsp_outstanding),
    .alloc_count         (alloc_count),
    .freed_count         (freed_count),
    .not_found_count     (not_found_count),
    .no_space_count      (no_space_count),
    .split_count         (split_count),
    .whole_on_full_count (whole_on_full_count),
    .peak_blocks         (peak_blocks)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.status == ffba_pkg::ST_ALLOCATED) begin
      live_addr.push_back(out_data.payload_address);
    end
  end

  function automatic ffba_pkg::alloc_req_t make_req(input logic op, input int unsigned size,
                                                    input int unsigned addr);
    ffba_pkg::alloc_req_t req;
    req.opcode        = op;
    req.alloc_size    = size[15:0];
    req.block_address = addr[15:0];
    return req;
  endfunction

  function automatic ffba_pkg::alloc_req_t random_request();
    ffba_pkg::alloc_req_t req;
    int unsigned pick;
    int unsigned idx;
    req.opcode        = ffba_pkg::OP_FREE;
    req.alloc_size    = 16'($urandom_range(65535));
    req.block_address = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 55) begin
      req.opcode = ffba_pkg::OP_ALLOC;
      case ($urandom_range(9))
        0:       req.alloc_size = '0;
        1, 2:    req.alloc_size = 16'($urandom_range(4095));
        3:       req.alloc_size = 16'($urandom_range(65535));
        default: req.alloc_size = 16'($urandom_range(255));
      endcase
    end else if (pick < 90 && live_addr.size() > 0) begin
      idx = $urandom_range(live_addr.size() - 1);
      req.block_address = live_addr[idx];
      freed_addr.push_back(live_addr[idx]);
      live_addr.delete(idx);
    end else if (pick < 95 && freed_addr.size() > 0) begin
      req.block_address = freed_addr[$urandom_range(freed_addr.size() - 1)];
    end else if (pick < 97 && live_addr.size() > 0) begin
      req.block_address = live_addr[0] + 16'd1;
    end
    return req;
  endfunction

  task automatic send_request(input ffba_pkg::alloc_req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (!steady_flow && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65535, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 0,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 200,   65535));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     80));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  65535, 80));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     81));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 100,   0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 60,    0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     40));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 0,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65535, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65176, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 0,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     320));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65176, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     320));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65136, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     320));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 65135, 0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 1,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     65495));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     320));
    directed_reqs.push_back(make_req(ffba_pkg::OP_ALLOC, 0,     0));
    directed_reqs.push_back(make_req(ffba_pkg::OP_FREE,  0,     65535));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[k]) begin
      send_request(directed_reqs[k]);
      maybe_pause();
    end

    for (int k = 0; k < 830; k++) begin
      steady_flow <= (k >= 300 && k < 420);
      send_request(random_request());
      maybe_pause();
    end
    in_valid    <= 1'b0;
    steady_flow <= 1'b0;

    @(posedge clk);
    while (rsp_outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Run covered %0d allocations, %0d frees, %0d unknown-address frees, %0d no-space.",
             alloc_count, freed_count, not_found_count, no_space_count);
    $display("Splits: %0d, whole hand-outs with a full table: %0d, largest table: %0d entries.",
             split_count, whole_on_full_count, peak_blocks);
    if (error_count == 0 && rsp_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // A correct run needs at most about 1.5 ms; this leaves a wide margin.
  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator_unit.sv
test/first_fit_block_allocator_checker.sv
test/tb_first_fit_block_allocator_unit.sv
